// ===== hdl/ppts_pkg.sv =====
// shared types, constants and table builders for the photon pulse template sum
// no dependencies; imported by every module of the block
package ppts_pkg;

    localparam int PAIRS = 3;
    localparam int INT_STEPS = 16;
    localparam logic [63:0] Q30_ONE = 64'd1073741824;

    localparam logic [15:0] LEAD_OFF = 16'd43542;
    localparam logic [15:0] RISE_OFF = 16'd41681;
    localparam logic [15:0] LEAD_K = 16'd52825;
    localparam logic [15:0] RISE_K = 16'd20739;
    localparam logic [15:0] FAST_RATE = 16'd58982;
    localparam logic [15:0] SLOW_RATE = 16'd18658;
    localparam logic [15:0] FAST_WEIGHT = 16'd51502;
    localparam logic [15:0] SLOW_WEIGHT = 16'd10077;
    localparam logic [14:0] NORM_RECIP = 15'd21501;
    localparam logic [26:0] PENALTY_INT = 27'd83988281;

    typedef enum logic [1:0] {
        RGN_LEAD = 2'd0,
        RGN_RISE = 2'd1,
        RGN_TAIL = 2'd2
    } region_t;

    // exp(-x) for x in q30, truncated taylor series
    function automatic logic [30:0] taylor_q30(input logic [63:0] x);
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        term = Q30_ONE;
        pos = Q30_ONE;
        neg = 64'd0;
        for (int j = 1; j <= 24; j++) begin
            term = ((term * x) >> 30) / 64'(j);
            if (j % 2 == 1) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        return (pos > neg) ? 31'(pos - neg) : 31'd0;
    endfunction

    // exp(-k) in q30 by repeated rounded multiplication
    function automatic logic [30:0] int_exp_q30(input int k);
        logic [63:0] e1;
        logic [63:0] acc;
        e1 = 64'(taylor_q30(Q30_ONE));
        acc = (k == 0) ? Q30_ONE : e1;
        for (int i = 2; i < INT_STEPS; i++) begin
            if (i <= k) begin
                acc = (acc * e1 + 64'd536870912) >> 30;
            end
        end
        return 31'(acc);
    endfunction

endpackage

// ===== hdl/ppts_exp.sv =====
// three-stage exp(-a) unit, a in q16, result in q16
// uses ppts_pkg for the table builders
module ppts_exp import ppts_pkg::*; #(
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        en,
    input  logic [23:0] arg,
    output logic [16:0] result
);

    localparam int IW = $clog2(EXP_TABLE_DEPTH);

    logic [30:0] int_rom [INT_STEPS];
    logic [30:0] frac_rom [EXP_TABLE_DEPTH];

    for (genvar k = 0; k < INT_STEPS; k++) begin : g_int
        assign int_rom[k] = int_exp_q30(k);
    end
    for (genvar i = 0; i < EXP_TABLE_DEPTH; i++) begin : g_frac
        assign frac_rom[i] = taylor_q30((64'(i) << 30) / EXP_TABLE_DEPTH);
    end

    logic [31:0] idx_full;
    logic [IW-1:0] idx;
    logic [30:0] ei_reg;
    logic [30:0] ef_reg;
    logic zero_reg;
    logic zero2_reg;
    logic [61:0] prod_reg;
    logic [16:0] result_reg;
    logic [61:0] rnd;

    assign idx_full = (32'(arg[15:0]) * 32'(EXP_TABLE_DEPTH)) >> 16;
    assign idx = idx_full[IW-1:0];
    assign rnd = prod_reg + (62'd1 << 43);

    always_ff @(posedge aclk) begin
        if (en) begin
            ei_reg <= int_rom[arg[19:16]];
            ef_reg <= frac_rom[idx];
            zero_reg <= |arg[23:20];
            prod_reg <= 62'(ei_reg) * 62'(ef_reg);
            zero2_reg <= zero_reg;
            result_reg <= zero2_reg ? 17'd0 : rnd[60:44];
        end
    end

    assign result = result_reg;

endmodule

// ===== hdl/ppts_lane.sv =====
// one pulse lane: offset, shape region, gaussian or two-exponential shape, weighting
// uses ppts_pkg and two ppts_exp units; nine register stages
module ppts_lane import ppts_pkg::*; #(
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        en,
    input  logic [15:0] sample_time,
    input  logic [15:0] amplitude,
    input  logic [15:0] arrival,
    input  logic        active,
    output logic [31:0] weighted,
    output logic        penalty
);

    // stage 1
    logic signed [16:0] d_reg;
    logic [15:0] amp1_reg;
    logic act1_reg;
    // stage 2
    region_t rgn2_reg;
    logic [18:0] m_reg;
    logic [23:0] a1_2_reg;
    logic [23:0] a2_2_reg;
    logic [15:0] amp2_reg;
    logic act2_reg;
    // stage 3
    region_t rgn3_reg;
    logic [21:0] sq_reg;
    logic [23:0] a1_3_reg;
    logic [23:0] a2_3_reg;
    logic [15:0] amp3_reg;
    logic act3_reg;
    // stage 4
    region_t rgn_reg [4];
    logic [15:0] amp_reg [4];
    logic act_reg [4];
    logic [23:0] ea_reg;
    logic [23:0] eb_reg;
    // stage 8, 9
    logic [16:0] shape_reg;
    logic [15:0] amp8_reg;
    logic act8_reg;
    logic [31:0] weighted_reg;
    logic penalty_reg;

    region_t rgn_d;
    logic signed [25:0] u;
    logic [24:0] mag;
    logic [31:0] p1;
    logic [31:0] p2;
    logic [37:0] sqf;
    logic [37:0] gaf;
    logic [16:0] e1;
    logic [16:0] e2;
    logic [31:0] tail_sum;

    always_comb begin
        if (d_reg <= -17'sd180) begin
            rgn_d = RGN_LEAD;
        end else if (d_reg < 17'sd256) begin
            rgn_d = RGN_RISE;
        end else begin
            rgn_d = RGN_TAIL;
        end
        u = 26'(signed'({d_reg, 8'd0}))
            + 26'(signed'({10'd0, (rgn_d == RGN_LEAD) ? LEAD_OFF : RISE_OFF}));
        mag = u[25] ? 25'(-u) : u[24:0];
        p1 = 32'(d_reg[15:0]) * 32'(FAST_RATE);
        p2 = 32'(d_reg[15:0]) * 32'(SLOW_RATE);
        sqf = 38'(m_reg) * 38'(m_reg);
        gaf = 38'(sq_reg) * 38'((rgn3_reg == RGN_LEAD) ? LEAD_K : RISE_K);
        tail_sum = 32'(FAST_WEIGHT) * 32'(e1) + 32'(SLOW_WEIGHT) * 32'(e2) + 32'd32768;
    end

    ppts_exp #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_exp_a (
        .aclk(aclk), .en(en), .arg(ea_reg), .result(e1)
    );
    ppts_exp #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_exp_b (
        .aclk(aclk), .en(en), .arg(eb_reg), .result(e2)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= signed'({1'b0, sample_time}) - signed'({1'b0, arrival});
            amp1_reg <= amplitude;
            act1_reg <= active;

            rgn2_reg <= rgn_d;
            m_reg <= (|mag[24:19]) ? '1 : mag[18:0];
            a1_2_reg <= p1[31:8];
            a2_2_reg <= p2[31:8];
            amp2_reg <= amp1_reg;
            act2_reg <= act1_reg;

            rgn3_reg <= rgn2_reg;
            sq_reg <= sqf[37:16];
            a1_3_reg <= a1_2_reg;
            a2_3_reg <= a2_2_reg;
            amp3_reg <= amp2_reg;
            act3_reg <= act2_reg;

            ea_reg <= (rgn3_reg == RGN_TAIL) ? a1_3_reg : {2'd0, gaf[37:16]};
            eb_reg <= a2_3_reg;
            rgn_reg[0] <= rgn3_reg;
            amp_reg[0] <= amp3_reg;
            act_reg[0] <= act3_reg;
            for (int s = 1; s < 4; s++) begin
                rgn_reg[s] <= rgn_reg[s-1];
                amp_reg[s] <= amp_reg[s-1];
                act_reg[s] <= act_reg[s-1];
            end

            shape_reg <= (rgn_reg[3] == RGN_TAIL) ? {1'b0, tail_sum[31:16]} : e1;
            amp8_reg <= amp_reg[3];
            act8_reg <= act_reg[3];

            weighted_reg <= (act8_reg && !amp8_reg[15]) ?
                32'(amp8_reg[14:0]) * 32'(shape_reg) : 32'd0;
            penalty_reg <= act8_reg && amp8_reg[15];
        end
    end

    assign weighted = weighted_reg;
    assign penalty = penalty_reg;

endmodule

// ===== hdl/photon_pulse_template_sum.sv =====
// an accepted input passes the lane stages, then psum_reg, x_reg and out_reg
// throughput: one transaction per cycle; all stages advance together unless the output stalls
// lanes run in parallel, one per pulse; the exp tables are constant logic
// reset: synchronous active-low aresetn clears valid bits and loads pulses_in_use = 1, others 0
// no clearing pass; the block accepts input from the first cycle after reset
module photon_pulse_template_sum import ppts_pkg::*; #(
    parameter int MAX_PULSES = 3,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample_time
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] waveform_value
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LANES = (MAX_PULSES < PAIRS) ? MAX_PULSES : PAIRS;
    localparam int CW = $clog2(LANES + 1);
    localparam int PW = 32 + CW;
    localparam int LAT = 12;

    localparam logic [2:0] IDX_COUNT = 3'd0;
    localparam logic [2:0] IDX_AMP1 = 3'd1;
    localparam logic [2:0] IDX_ARR1 = 3'd2;
    localparam logic [2:0] IDX_AMP2 = 3'd3;
    localparam logic [2:0] IDX_ARR2 = 3'd4;
    localparam logic [2:0] IDX_AMP3 = 3'd5;
    localparam logic [2:0] IDX_ARR3 = 3'd6;

    logic [1:0] count_reg;
    logic [15:0] amp_cfg_reg [PAIRS];
    logic [15:0] arr_cfg_reg [PAIRS];
    logic cfg_wr;
    logic [2:0] cfg_idx;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd1;
            for (int i = 0; i < PAIRS; i++) begin
                amp_cfg_reg[i] <= 16'd0;
                arr_cfg_reg[i] <= 16'd0;
            end
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                IDX_COUNT: count_reg <= pwdata[1:0];
                IDX_AMP1:  amp_cfg_reg[0] <= pwdata[15:0];
                IDX_ARR1:  arr_cfg_reg[0] <= pwdata[15:0];
                IDX_AMP2:  amp_cfg_reg[1] <= pwdata[15:0];
                IDX_ARR2:  arr_cfg_reg[1] <= pwdata[15:0];
                IDX_AMP3:  amp_cfg_reg[2] <= pwdata[15:0];
                IDX_ARR3:  arr_cfg_reg[2] <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            IDX_COUNT: prdata = {30'd0, count_reg};
            IDX_AMP1:  prdata = {16'd0, amp_cfg_reg[0]};
            IDX_ARR1:  prdata = {16'd0, arr_cfg_reg[0]};
            IDX_AMP2:  prdata = {16'd0, amp_cfg_reg[1]};
            IDX_ARR2:  prdata = {16'd0, arr_cfg_reg[1]};
            IDX_AMP3:  prdata = {16'd0, amp_cfg_reg[2]};
            IDX_ARR3:  prdata = {16'd0, arr_cfg_reg[2]};
            default:   prdata = 32'd0;
        endcase
    end

    // pipeline control
    logic en;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    assign en = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign vld_next = {vld_reg[LAT-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    // pulse lanes
    logic [31:0] weighted [LANES];
    logic penalty [LANES];

    for (genvar p = 0; p < LANES; p++) begin : g_lane
        ppts_lane #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_lane (
            .aclk(aclk),
            .en(en),
            .sample_time(s_tdata),
            .amplitude(amp_cfg_reg[p]),
            .arrival(arr_cfg_reg[p]),
            .active(2'(p) < count_reg),
            .weighted(weighted[p]),
            .penalty(penalty[p])
        );
    end

    // sum, normalize, subtract penalties, saturate
    logic [PW-1:0] psum_reg;
    logic [PW-1:0] psum_next;
    logic [CW-1:0] pcnt_reg;
    logic [CW-1:0] pcnt_next;
    logic [CW-1:0] pcnt2_reg;
    logic signed [50:0] x_reg;
    logic [31:0] out_reg;
    logic [49:0] xpos;
    logic signed [18:0] q;
    logic signed [33:0] r;

    always_comb begin
        psum_next = '0;
        pcnt_next = '0;
        for (int i = 0; i < LANES; i++) begin
            psum_next = psum_next + PW'(weighted[i]);
            pcnt_next = pcnt_next + CW'(penalty[i]);
        end
        xpos = 50'(psum_reg) * 50'(NORM_RECIP) + (50'd1 << 31);
        q = x_reg[50:32];
        r = 34'(q) - signed'(34'(pcnt2_reg) * 34'(PENALTY_INT));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            psum_reg <= psum_next;
            pcnt_reg <= pcnt_next;
            x_reg <= signed'({1'b0, xpos}) - signed'(51'(pcnt_reg) << 30);
            pcnt2_reg <= pcnt_reg;
            if (r > 34'sd2147483647) begin
                out_reg <= 32'h7fffffff;
            end else if (r < -34'sd2147483648) begin
                out_reg <= 32'h80000000;
            end else begin
                out_reg <= r[31:0];
            end
        end
    end

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata = out_reg;

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted transaction not tracked");
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(vld_reg))
        else $error("pipeline moved during output stall");
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && count_reg == 2'd1)
        else $error("reset state wrong");

endmodule
